### hw/rtl/cpag_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpag_pkg
// types, board masks and attack helper functions for the attack generator
// ----------------------------------------------------------------------------
package cpag_pkg;

  typedef enum logic [2:0] {
    OP_ROOK        = 3'd0,
    OP_BISHOP      = 3'd1,
    OP_QUEEN       = 3'd2,
    OP_KNIGHT      = 3'd3,
    OP_KING        = 3'd4,
    OP_WHITE_PAWNS = 3'd5,
    OP_BLACK_PAWNS = 3'd6
  } op_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  square;
    logic [63:0] board;
  } item_t;

  localparam logic [63:0] FILE_A_MASK = 64'h0101_0101_0101_0101;
  localparam logic [63:0] FILE_H_MASK = 64'h8080_8080_8080_8080;

  localparam logic signed [1:0] STEP_POS  = 2'sd1;
  localparam logic signed [1:0] STEP_NEG  = -2'sd1;
  localparam logic signed [1:0] STEP_NONE = 2'sd0;

  localparam int RAY_LEN = 7;

  localparam logic signed [2:0] KNIGHT_DF [8] = '{3'sd1, -3'sd1, 3'sd2, -3'sd2,
                                                  3'sd1, -3'sd1, 3'sd2, -3'sd2};
  localparam logic signed [2:0] KNIGHT_DR [8] = '{3'sd2, 3'sd2, 3'sd1, 3'sd1,
                                                  -3'sd2, -3'sd2, -3'sd1, -3'sd1};

  localparam logic signed [1:0] KING_DF [8] = '{-2'sd1, 2'sd0, 2'sd1, -2'sd1,
                                                2'sd1, -2'sd1, 2'sd0, 2'sd1};
  localparam logic signed [1:0] KING_DR [8] = '{-2'sd1, -2'sd1, -2'sd1, 2'sd0,
                                                2'sd0, 2'sd1, 2'sd1, 2'sd1};

  function automatic logic on_board(logic signed [4:0] f, logic signed [4:0] r);
    return (f >= 5'sd0) && (f < 5'sd8) && (r >= 5'sd0) && (r < 5'sd8);
  endfunction

  // one sliding ray, stops at and includes the first blocker
  function automatic logic [63:0] ray_attacks(logic [5:0] sq, logic signed [1:0] df,
                                              logic signed [1:0] dr, logic [63:0] blk);
    logic [63:0]       acc;
    logic signed [4:0] f;
    logic signed [4:0] r;
    logic              stop;
    acc  = '0;
    f    = signed'({2'b00, sq[2:0]});
    r    = signed'({2'b00, sq[5:3]});
    stop = 1'b0;
    for (int k = 0; k < RAY_LEN; k++) begin
      f = f + 5'(df);
      r = r + 5'(dr);
      if (!stop && on_board(f, r)) begin
        acc[{r[2:0], f[2:0]}] = 1'b1;
        if (blk[{r[2:0], f[2:0]}]) stop = 1'b1;
      end else begin
        stop = 1'b1;
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] knight_attacks(logic [5:0] sq);
    logic [63:0]       acc;
    logic signed [4:0] f;
    logic signed [4:0] r;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      f = signed'({2'b00, sq[2:0]}) + 5'(KNIGHT_DF[k]);
      r = signed'({2'b00, sq[5:3]}) + 5'(KNIGHT_DR[k]);
      if (on_board(f, r)) acc[{r[2:0], f[2:0]}] = 1'b1;
    end
    return acc;
  endfunction

  function automatic logic [63:0] king_attacks(logic [5:0] sq);
    logic [63:0]       acc;
    logic signed [4:0] f;
    logic signed [4:0] r;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      f = signed'({2'b00, sq[2:0]}) + 5'(KING_DF[k]);
      r = signed'({2'b00, sq[5:3]}) + 5'(KING_DR[k]);
      if (on_board(f, r)) acc[{r[2:0], f[2:0]}] = 1'b1;
    end
    return acc;
  endfunction

endpackage

### hw/rtl/chess_piece_attack_generator.sv
`timescale 1ns / 1ps
// an accepted item passes the item register and then the result register before its result strobe
// throughput: one item per cycle, busy_o is always low
// the path is input register, ray and mask logic, result register; the longest
// chain is a seven-square blocker walk along one ray
// reset: rst_ni low clears the item and result valid flags, no result is in flight
// the receiver cannot stall, every strobe lasts exactly one cycle
// ----------------------------------------------------------------------------
// chess_piece_attack_generator
// bitboard attack sets for sliders, knight, king and pawn captures on 8x8
// ----------------------------------------------------------------------------
module chess_piece_attack_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  op_i,
  input  logic [5:0]  square_i,
  input  logic [63:0] board_i,
  output logic        valid_o,
  output logic [63:0] attacks_o
);

  // item register
  logic            item_vld_q;
  cpag_pkg::item_t item_q;
  cpag_pkg::item_t item_d;

  // result register
  logic            res_vld_q;
  logic [63:0]     res_q;
  logic [63:0]     res_d;

  logic            accept;

  // fully pipelined, never holds off a new item
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign item_d.op     = op_i;
  assign item_d.square = square_i;
  assign item_d.board  = board_i;

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      item_vld_q <= accept;
      res_vld_q  <= item_vld_q;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
    if (item_vld_q) begin
      res_q <= res_d;
    end
  end

  // combinational attack logic between the two registers
  cpag_attack u_attack (
    .item_i    (item_q),
    .attacks_o (res_d)
  );

  assign valid_o   = res_vld_q;
  assign attacks_o = res_q;

`ifndef NO_ASSERTIONS
  // every accepted item yields a strobe once it has passed the item and result registers
  a_start_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 valid_o)
    else $error("accepted item did not produce a result");

  // no strobe without an item accepted ahead of it through the item and result registers
  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, 2))
    else $error("result strobe without an accepted item");

  // knight and king never attack their own square
  a_jump_not_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && ($past(op_i, 2) == 3'(cpag_pkg::OP_KNIGHT)
              || $past(op_i, 2) == 3'(cpag_pkg::OP_KING)))
    |-> !attacks_o[$past(square_i, 2)])
    else $error("jump set contains the origin square");

  // white pawn captures never land on the first rank
  a_white_pawn_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(op_i, 2) == 3'(cpag_pkg::OP_WHITE_PAWNS)) |-> attacks_o[7:0] == 8'h00)
    else $error("white pawn capture on the first rank");
`endif

endmodule

### hw/rtl/cpag_attack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpag_attack
// attack set of one registered item: slider rays, jump sets, pawn captures
// ----------------------------------------------------------------------------
module cpag_attack (
  input  cpag_pkg::item_t item_i,
  output logic [63:0]     attacks_o
);

  logic [63:0] ortho;
  logic [63:0] diag;
  logic [63:0] white_caps;
  logic [63:0] black_caps;

  always_comb begin
    ortho = cpag_pkg::ray_attacks(item_i.square, cpag_pkg::STEP_POS, cpag_pkg::STEP_NONE,
                                  item_i.board)
          | cpag_pkg::ray_attacks(item_i.square, cpag_pkg::STEP_NEG, cpag_pkg::STEP_NONE,
                                  item_i.board)
          | cpag_pkg::ray_attacks(item_i.square, cpag_pkg::STEP_NONE, cpag_pkg::STEP_POS,
                                  item_i.board)
          | cpag_pkg::ray_attacks(item_i.square, cpag_pkg::STEP_NONE, cpag_pkg::STEP_NEG,
                                  item_i.board);
    diag  = cpag_pkg::ray_attacks(item_i.square, cpag_pkg::STEP_POS, cpag_pkg::STEP_POS,
                                  item_i.board)
          | cpag_pkg::ray_attacks(item_i.square, cpag_pkg::STEP_NEG, cpag_pkg::STEP_POS,
                                  item_i.board)
          | cpag_pkg::ray_attacks(item_i.square, cpag_pkg::STEP_POS, cpag_pkg::STEP_NEG,
                                  item_i.board)
          | cpag_pkg::ray_attacks(item_i.square, cpag_pkg::STEP_NEG, cpag_pkg::STEP_NEG,
                                  item_i.board);
    // no wrap across the a or h file
    white_caps = ((item_i.board << 9) & ~cpag_pkg::FILE_A_MASK)
               | ((item_i.board << 7) & ~cpag_pkg::FILE_H_MASK);
    black_caps = ((item_i.board >> 7) & ~cpag_pkg::FILE_A_MASK)
               | ((item_i.board >> 9) & ~cpag_pkg::FILE_H_MASK);
  end

  always_comb begin
    unique case (item_i.op)
      cpag_pkg::OP_ROOK:        attacks_o = ortho;
      cpag_pkg::OP_BISHOP:      attacks_o = diag;
      cpag_pkg::OP_QUEEN:       attacks_o = ortho | diag;
      cpag_pkg::OP_KNIGHT:      attacks_o = cpag_pkg::knight_attacks(item_i.square);
      cpag_pkg::OP_KING:        attacks_o = cpag_pkg::king_attacks(item_i.square);
      cpag_pkg::OP_WHITE_PAWNS: attacks_o = white_caps;
      cpag_pkg::OP_BLACK_PAWNS: attacks_o = black_caps;
      default:                  attacks_o = '0;
    endcase
  end

endmodule
